### rtl/lds_pkg.sv
// shared types and constants for the look disk scheduler
package lds_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 16;

  localparam int CNT_W       = $clog2(MAX_REQUESTS + 1);
  localparam int AW          = $clog2(MAX_REQUESTS);
  localparam int TCOUNT_W    = TRACK_BITS + 1;
  localparam int SEEK_W      = TRACK_BITS + 1;
  localparam int IN_DATA_W   = ((TRACK_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((TRACK_BITS + SEEK_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = TCOUNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TRACK  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = CFG_IDX_W'(2);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_SERVICE = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RA_CNT_M1,
    RA_PTR_M2,
    RA_ZERO,
    RA_PTR_P1,
    RA_SRV,
    RA_SRV_P1
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_CHK,
    ST_LD_SHIFT,
    ST_LD_PUT,
    ST_LD_ACK,
    ST_LD_NAK,
    ST_SCH_CHK,
    ST_SPLIT,
    ST_SV_RD,
    ST_SV_EM,
    ST_EMPTY
  } ctrl_state_t;

  typedef struct packed {
    logic    latch_in;
    logic    ptr_ld_cnt;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    ptr_clr;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_from_rd;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    split_ld;
    logic    srv_init;
    logic    out_load;
    kind_t   out_kind;
  } lds_cmd_t;

  typedef struct packed {
    logic reject;
    logic cnt_zero;
    logic rd_gt_trk;
    logic ptr_is_one;
    logic rd_gt_pos;
    logic ptr_is_last;
    logic srv_last;
    logic out_free;
  } lds_sts_t;

endpackage

### rtl/lds_ctrl.sv
// control state machine for the look disk scheduler
module lds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  lds_pkg::lds_sts_t st,
  output lds_pkg::lds_cmd_t cmd
);

  lds_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lds_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_cmd == lds_pkg::CMD_START) ? lds_pkg::ST_SCH_CHK : lds_pkg::ST_LD_CHK;
        end
      end
      lds_pkg::ST_LD_CHK: begin
        if (st.reject) begin
          state_nxt = lds_pkg::ST_LD_NAK;
        end else if (st.cnt_zero) begin
          state_nxt = lds_pkg::ST_LD_PUT;
        end else begin
          state_nxt = lds_pkg::ST_LD_SHIFT;
        end
      end
      lds_pkg::ST_LD_SHIFT: begin
        if (!st.rd_gt_trk) begin
          state_nxt = lds_pkg::ST_LD_ACK;
        end else if (st.ptr_is_one) begin
          state_nxt = lds_pkg::ST_LD_PUT;
        end
      end
      lds_pkg::ST_LD_PUT:  state_nxt = lds_pkg::ST_LD_ACK;
      lds_pkg::ST_LD_ACK,
      lds_pkg::ST_LD_NAK,
      lds_pkg::ST_EMPTY: begin
        if (st.out_free) begin
          state_nxt = lds_pkg::ST_IDLE;
        end
      end
      lds_pkg::ST_SCH_CHK: begin
        state_nxt = st.cnt_zero ? lds_pkg::ST_EMPTY : lds_pkg::ST_SPLIT;
      end
      lds_pkg::ST_SPLIT: begin
        if (st.rd_gt_pos || st.ptr_is_last) begin
          state_nxt = lds_pkg::ST_SV_RD;
        end
      end
      lds_pkg::ST_SV_RD:   state_nxt = lds_pkg::ST_SV_EM;
      lds_pkg::ST_SV_EM: begin
        if (st.out_free && st.srv_last) begin
          state_nxt = lds_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = lds_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.rd_sel   = lds_pkg::RA_ZERO;
    cmd.out_kind = lds_pkg::KIND_ACCEPT;
    in_tready = 1'b0;
    case (state_r)
      lds_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
      end
      lds_pkg::ST_LD_CHK: begin
        if (!st.reject) begin
          cmd.ptr_ld_cnt = 1'b1;
          if (!st.cnt_zero) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lds_pkg::RA_CNT_M1;
          end
        end
      end
      lds_pkg::ST_LD_SHIFT: begin
        cmd.wr_en = 1'b1;
        if (st.rd_gt_trk) begin
          cmd.wr_from_rd = 1'b1;
          cmd.ptr_dec    = 1'b1;
          if (!st.ptr_is_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lds_pkg::RA_PTR_M2;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      lds_pkg::ST_LD_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      lds_pkg::ST_LD_ACK: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = lds_pkg::KIND_ACCEPT;
      end
      lds_pkg::ST_LD_NAK: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = lds_pkg::KIND_REJECT;
      end
      lds_pkg::ST_EMPTY: begin
        cmd.out_load = st.out_free;
        cmd.out_kind = lds_pkg::KIND_EMPTY;
      end
      lds_pkg::ST_SCH_CHK: begin
        if (!st.cnt_zero) begin
          cmd.srv_init = 1'b1;
          cmd.ptr_clr  = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = lds_pkg::RA_ZERO;
        end
      end
      lds_pkg::ST_SPLIT: begin
        if (st.rd_gt_pos || st.ptr_is_last) begin
          cmd.split_ld = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = lds_pkg::RA_PTR_P1;
        end
      end
      lds_pkg::ST_SV_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lds_pkg::RA_SRV;
      end
      lds_pkg::ST_SV_EM: begin
        cmd.out_kind = lds_pkg::KIND_SERVICE;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.srv_last) begin
            cmd.cnt_clr = 1'b1;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lds_pkg::RA_SRV_P1;
          end
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/lds_dp.sv
// datapath: sorted request memory, sweep arithmetic and output register
module lds_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lds_pkg::lds_cmd_t                 cmd,
  output lds_pkg::lds_sts_t                 st,
  input  logic [lds_pkg::TRACK_BITS-1:0]    in_track,
  input  logic [lds_pkg::TCOUNT_W-1:0]      track_count,
  input  logic [lds_pkg::TRACK_BITS-1:0]    head_track,
  input  logic                              direction,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [lds_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int TB   = lds_pkg::TRACK_BITS;
  localparam int CW   = lds_pkg::CNT_W;
  localparam int AW   = lds_pkg::AW;
  localparam int SW   = lds_pkg::SEEK_W;
  localparam int PADW = lds_pkg::OUT_DATA_W - TB - SW;

  logic [TB-1:0] mem [lds_pkg::MAX_REQUESTS];

  logic [TB-1:0] trk_r;
  logic [TB-1:0] rd_data_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] split_r;
  logic [CW-1:0] srv_r;
  logic [TB-1:0] pos_r;
  logic [SW-1:0] seek_r;

  logic              out_valid_r;
  lds_pkg::kind_t    out_kind_r;
  logic [TB-1:0]     out_trk_r;
  logic [SW-1:0]     out_seek_r;
  logic              out_last_r;

  logic [AW-1:0] rd_addr;
  logic [TB-1:0] trk_gap;
  logic [SW-1:0] seek_sum;
  logic [CW-1:0] cnt_m1;

  // order of service: lower side downward then upper side upward, or the reverse
  function automatic logic [AW-1:0] serve_index(input logic [CW-1:0] k,
                                                input logic [CW-1:0] split,
                                                input logic [CW-1:0] n,
                                                input logic          dir);
    logic [CW-1:0] idx;
    begin
      if (!dir) begin
        idx = (k < split) ? (split - k - CW'(1)) : k;
      end else begin
        idx = (k < (n - split)) ? (split + k) : (n - k - CW'(1));
      end
      serve_index = idx[AW-1:0];
    end
  endfunction

  assign cnt_m1   = cnt_r - CW'(1);
  assign trk_gap  = (rd_data_r > pos_r) ? (rd_data_r - pos_r) : (pos_r - rd_data_r);
  assign seek_sum = seek_r + SW'(trk_gap);

  always_comb begin
    case (cmd.rd_sel)
      lds_pkg::RA_CNT_M1: rd_addr = cnt_m1[AW-1:0];
      lds_pkg::RA_PTR_M2: rd_addr = AW'(ptr_r - CW'(2));
      lds_pkg::RA_ZERO:   rd_addr = '0;
      lds_pkg::RA_PTR_P1: rd_addr = AW'(ptr_r + CW'(1));
      lds_pkg::RA_SRV:    rd_addr = serve_index(srv_r, split_r, cnt_r, direction);
      lds_pkg::RA_SRV_P1: rd_addr = serve_index(srv_r + CW'(1), split_r, cnt_r, direction);
      default:            rd_addr = '0;
    endcase
  end

  // request memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr_r[AW-1:0]] <= cmd.wr_from_rd ? rd_data_r : trk_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      trk_r <= in_track;
    end
    if (cmd.ptr_ld_cnt) begin
      ptr_r <= cnt_r;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - CW'(1);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CW'(1);
    end
    if (cmd.split_ld) begin
      split_r <= (rd_data_r > pos_r) ? ptr_r : cnt_r;
    end
    if (cmd.srv_init) begin
      pos_r  <= head_track;
      seek_r <= '0;
    end else if (cmd.out_load && (cmd.out_kind == lds_pkg::KIND_SERVICE)) begin
      pos_r  <= rd_data_r;
      seek_r <= seek_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      srv_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.srv_init) begin
        srv_r <= '0;
      end else if (cmd.out_load && (cmd.out_kind == lds_pkg::KIND_SERVICE)) begin
        srv_r <= srv_r + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      if (cmd.out_kind == lds_pkg::KIND_SERVICE) begin
        out_trk_r  <= rd_data_r;
        out_last_r <= st.srv_last;
        out_seek_r <= st.srv_last ? seek_sum : '0;
      end else begin
        out_trk_r  <= '0;
        out_last_r <= 1'b1;
        out_seek_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_seek_r, out_trk_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    st.reject      = ({1'b0, trk_r} >= track_count) || (cnt_r >= CW'(lds_pkg::MAX_REQUESTS));
    st.cnt_zero    = (cnt_r == '0);
    st.rd_gt_trk   = (rd_data_r > trk_r);
    st.ptr_is_one  = (ptr_r == CW'(1));
    st.rd_gt_pos   = (rd_data_r > pos_r);
    st.ptr_is_last = (ptr_r == cnt_m1);
    st.srv_last    = (srv_r == cnt_m1);
    st.out_free    = !out_valid_r || out_tready;
  end

endmodule

### rtl/look_disk_scheduler_top.sv
// top level of the look disk scheduler: config registers, controller and datapath
//
// LOOK disk scheduler. An add item (in_tuser = 0) inserts one track request into a
// sorted store of up to 64 entries and answers with one result: accepted, or rejected
// when the track is at or above track_count or the store is full. A start item
// (in_tuser = 1) serves every stored request from head_track, first sweeping in the
// configured direction to the farthest request on that side, then reversing; one
// service result is sent per request, the last one with tlast and the total seek
// distance, and the store is emptied. A start with nothing stored answers with one
// empty-schedule result. Requests equal to the head count as the lower side.
// Timing: one item is handled at a time, and in_tready is high only while the block is
// idle. An add shifts each stored request above the new track up one place, as the
// single-port-write request memory shifts one entry per cycle. A start first scans the
// sorted store to locate the head (stopping at the first request above the head, or at
// the last stored one), then sends one service result per cycle while out_tready is
// held high. The result sits in an output register, so an item can be accepted while
// the previous result waits.
// Configuration writes are always taken (cfg_ready is tied high); index 3 is ignored.
module look_disk_scheduler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lds_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] track
  input  logic                              in_tuser,   // [0] command
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lds_pkg::OUT_DATA_W-1:0]    out_tdata,  // [15:0] served_track, [32:16] seek_total
  output logic [1:0]                        out_tuser,  // [1:0] kind
  output logic                              out_tlast,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [lds_pkg::TCOUNT_W-1:0]   track_count_r;
  logic [lds_pkg::TRACK_BITS-1:0] head_track_r;
  logic                           direction_r;

  lds_pkg::lds_cmd_t cmd;
  lds_pkg::lds_sts_t st;

  assign cfg_ready = 1'b1;

  // config registers, one transfer writes one register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r <= lds_pkg::TCOUNT_W'(1 << lds_pkg::TRACK_BITS);
      head_track_r  <= '0;
      direction_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lds_pkg::CFG_TRACK_COUNT: track_count_r <= cfg_data;
        lds_pkg::CFG_HEAD_TRACK:  head_track_r  <= cfg_data[lds_pkg::TRACK_BITS-1:0];
        lds_pkg::CFG_DIRECTION:   direction_r   <= cfg_data[0];
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lds_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_track    (in_tdata[lds_pkg::TRACK_BITS-1:0]),
    .track_count (track_count_r),
    .head_track  (head_track_r),
    .direction   (direction_r),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

### rtl/lds_checker.sv
// port-level checks for the look disk scheduler, bound to the top level
module lds_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lds_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);

  // a waiting result is not withdrawn
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

  // single-result kinds always end their run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != lds_pkg::KIND_SERVICE) |-> out_tlast && (out_tdata == '0))
    else $error("non-service result malformed");

  // seek total only shows on the final result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[lds_pkg::OUT_DATA_W-1:lds_pkg::TRACK_BITS] == '0))
    else $error("seek total on a non-final result");

endmodule

bind look_disk_scheduler_top lds_checker u_lds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
